// ----- hdl/mprq_pkg.sv -----
// mprq_pkg: shared types and codes for the multilevel priority run queue
// pool slot layout, operation and status codes, sequencer states, compare unit bundles
// no dependencies
`timescale 1ns / 1ps

package mprq_pkg;

	localparam int CoreW  = 3;
	localparam int PrioW  = 8;
	localparam int PidW   = 16;
	localparam int StampW = 32;

	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_POP    = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_PUSH
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [CoreW-1:0]  core;
		logic [PrioW-1:0]  level;
		logic [PidW-1:0]   id;
		logic [StampW-1:0] stamp;
	} slot_t;

	typedef struct packed {
		func_t             mode;
		logic [CoreW-1:0]  core;
		logic [PrioW-1:0]  prio;
		logic [PidW-1:0]   pid;
		logic [StampW-1:0] counter;
		logic              have;
		logic [PrioW-1:0]  blevel;
		logic [StampW-1:0] bage;
		slot_t             entry;
	} cmp_in_t;

	typedef struct packed {
		logic              take;
		logic [StampW-1:0] age;
	} cmp_out_t;

endpackage

// ----- hdl/multilevel_priority_run_queue_top.sv -----
// multilevel_priority_run_queue_top: per-core multilevel run queue over a shared slot pool
// depends on mprq_pkg, mprq_mem, mprq_cmp and mprq_ctrl
`timescale 1ns / 1ps

// usage:
// request channel req_valid/req_ready carries func, core, prio, pid; each item gives
// exactly one result on rsp_valid/rsp_ready as status, out_pid, out_prio.
// insert puts pid in the lowest free slot, pop takes the oldest entry of the most
// urgent non-empty level of a core, remove takes the newest matching entry.
// sequence: insert, pop and remove read every slot once through one read port, then
// pass the drain, write and push steps before the result is registered; the next
// item is taken only after the push step has handed the result to the output register.
// an item rejected for an out-of-range core or level, or an unused func code, skips
// the scan and goes straight to the push step.
// reset: after arst_n drops, a clearing pass writes every slot empty, one per cycle;
// req_ready stays low until it is done.
// a held result sits in the output register; the next item is accepted and worked
// meanwhile, and the block only waits if that item finishes before the receiver
// takes the previous result.
module multilevel_priority_run_queue_top
	import mprq_pkg::*;
#(
	parameter int CORES      = 8,
	parameter int PRIORITIES = 140,
	parameter int SLOTS      = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [1:0]       func,
	input  logic [CoreW-1:0] core,
	input  logic [PrioW-1:0] prio,
	input  logic [PidW-1:0]  pid,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [1:0]       status,
	output logic [PidW-1:0]  out_pid,
	output logic [PrioW-1:0] out_prio
);

	localparam int IdxW = $clog2(SLOTS);

	logic            mem_re;
	logic [IdxW-1:0] mem_raddr;
	slot_t           mem_rdata;
	logic            mem_we;
	logic [IdxW-1:0] mem_waddr;
	slot_t           mem_wdata;
	cmp_in_t         cmp_in;
	cmp_out_t        cmp_out;

	mprq_ctrl #(
		.CORES      (CORES),
		.PRIORITIES (PRIORITIES),
		.SLOTS      (SLOTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.func      (func),
		.core      (core),
		.prio      (prio),
		.pid       (pid),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (status),
		.out_pid   (out_pid),
		.out_prio  (out_prio),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.cmp_in    (cmp_in),
		.cmp_out   (cmp_out)
	);

	mprq_mem #(
		.SLOTS (SLOTS)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	mprq_cmp u_cmp (
		.cin  (cmp_in),
		.cout (cmp_out)
	);

endmodule

// ----- hdl/mprq_mem.sv -----
// mprq_mem: slot pool storage, one write port and one registered read port
// depends on mprq_pkg for the slot layout
`timescale 1ns / 1ps

module mprq_mem
	import mprq_pkg::*;
#(
	parameter int SLOTS = 64
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(SLOTS)-1:0] raddr,
	output slot_t                    rdata,
	input  logic                     we,
	input  logic [$clog2(SLOTS)-1:0] waddr,
	input  slot_t                    wdata
);

	slot_t mem [SLOTS];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/mprq_cmp.sv -----
// mprq_cmp: shared age and match unit, judges one pool slot against the current best
// depends on mprq_pkg for the compare bundles and codes
`timescale 1ns / 1ps

module mprq_cmp
	import mprq_pkg::*;
(
	input  cmp_in_t  cin,
	output cmp_out_t cout
);

	logic [StampW-1:0] age;
	logic              core_hit;
	logic              older;
	logic              newer;
	logic              more_urgent;
	logic              same_level;

	always_comb begin
		age         = cin.counter - cin.entry.stamp;
		core_hit    = cin.entry.valid && (cin.entry.core == cin.core);
		older       = age > cin.bage;
		newer       = age < cin.bage;
		more_urgent = cin.entry.level < cin.blevel;
		same_level  = cin.entry.level == cin.blevel;
		cout.age    = age;
		unique case (cin.mode)
			FN_INSERT: begin
				// first free slot in ascending scan
				cout.take = !cin.entry.valid && !cin.have;
			end
			FN_POP: begin
				cout.take = core_hit &&
					(!cin.have || more_urgent || (same_level && older));
			end
			FN_REMOVE: begin
				cout.take = core_hit && (cin.entry.level == cin.prio) &&
					(cin.entry.id == cin.pid) && (!cin.have || newer);
			end
			default: begin
				cout.take = 1'b0;
			end
		endcase
	end

endmodule

// ----- hdl/mprq_ctrl.sv -----
// mprq_ctrl: sequencer, clears the pool after reset, scans it at most once per item, updates it
// depends on mprq_pkg; drives mprq_mem and mprq_cmp
`timescale 1ns / 1ps

module mprq_ctrl
	import mprq_pkg::*;
#(
	parameter int CORES      = 8,
	parameter int PRIORITIES = 140,
	parameter int SLOTS      = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  logic [1:0]               func,
	input  logic [CoreW-1:0]         core,
	input  logic [PrioW-1:0]         prio,
	input  logic [PidW-1:0]          pid,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output logic [1:0]               status,
	output logic [PidW-1:0]          out_pid,
	output logic [PrioW-1:0]         out_prio,
	output logic                     mem_re,
	output logic [$clog2(SLOTS)-1:0] mem_raddr,
	input  slot_t                    mem_rdata,
	output logic                     mem_we,
	output logic [$clog2(SLOTS)-1:0] mem_waddr,
	output slot_t                    mem_wdata,
	output cmp_in_t                  cmp_in,
	input  cmp_out_t                 cmp_out
);

	localparam int IdxW = $clog2(SLOTS);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

	state_t state_q, state_d;

	logic [IdxW-1:0]   clr_q;
	logic [IdxW-1:0]   iss_q;
	logic              rdv_s1;
	logic [IdxW-1:0]   idx_s1;
	logic [StampW-1:0] cnt_q;

	func_t             func_q;
	logic [CoreW-1:0]  core_q;
	logic [PrioW-1:0]  prio_q;
	logic [PidW-1:0]   pid_q;

	logic              have_q;
	logic [IdxW-1:0]   bidx_q;
	logic [PrioW-1:0]  blevel_q;
	logic [StampW-1:0] bage_q;
	logic [PidW-1:0]   bid_q;

	status_t           res_st_q;
	logic [PidW-1:0]   res_pid_q;
	logic [PrioW-1:0]  res_prio_q;

	logic              rsp_valid_q;
	logic [1:0]        out_st_q;
	logic [PidW-1:0]   out_pid_q;
	logic [PrioW-1:0]  out_prio_q;

	logic              accept;
	logic              core_bad;
	logic              prio_bad;
	logic              out_free;

	assign accept   = req_valid && req_ready;
	assign core_bad = 32'(core) >= 32'(CORES);
	assign prio_bad = 32'(prio) >= 32'(PRIORITIES);
	assign out_free = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmp_in.mode    = func_q;
		cmp_in.core    = core_q;
		cmp_in.prio    = prio_q;
		cmp_in.pid     = pid_q;
		cmp_in.counter = cnt_q;
		cmp_in.have    = have_q;
		cmp_in.blevel  = blevel_q;
		cmp_in.bage    = bage_q;
		cmp_in.entry   = mem_rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = iss_q;
		mem_we    = 1'b0;
		mem_waddr = bidx_q;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LastIdx) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (func_t'(func))
						FN_INSERT: state_d = (core_bad || prio_bad) ? S_PUSH : S_SCAN;
						FN_POP:    state_d = core_bad ? S_PUSH : S_SCAN;
						FN_REMOVE: state_d = (core_bad || prio_bad) ? S_PUSH : S_SCAN;
						default:   state_d = S_PUSH;
					endcase
				end
			end
			S_SCAN: begin
				mem_re = 1'b1;
				if (iss_q == LastIdx) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_WRITE;
			end
			S_WRITE: begin
				mem_we = have_q;
				if (func_q == FN_INSERT) begin
					mem_wdata.valid = 1'b1;
					mem_wdata.core  = core_q;
					mem_wdata.level = prio_q;
					mem_wdata.id    = pid_q;
					mem_wdata.stamp = cnt_q;
				end
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			iss_q       <= '0;
			rdv_s1      <= 1'b0;
			cnt_q       <= '0;
			have_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == S_SCAN);
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (accept) begin
				iss_q  <= '0;
				have_q <= 1'b0;
			end else if (state_q == S_SCAN) begin
				iss_q <= iss_q + 1'b1;
			end
			if (rdv_s1 && cmp_out.take) begin
				have_q <= 1'b1;
			end
			if (state_q == S_WRITE && have_q && func_q == FN_INSERT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == S_PUSH && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// item fields, best candidate and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q;
		if (accept) begin
			func_q     <= func_t'(func);
			core_q     <= core;
			prio_q     <= prio;
			pid_q      <= pid;
			res_pid_q  <= '0;
			res_prio_q <= '0;
			unique case (func_t'(func))
				FN_INSERT: res_st_q <= ST_FULL;
				FN_POP:    res_st_q <= ST_EMPTY;
				FN_REMOVE: res_st_q <= ST_NOTFOUND;
				default:   res_st_q <= ST_OK;
			endcase
		end
		if (rdv_s1 && cmp_out.take) begin
			bidx_q   <= idx_s1;
			blevel_q <= mem_rdata.level;
			bage_q   <= cmp_out.age;
			bid_q    <= mem_rdata.id;
		end
		if (state_q == S_WRITE && have_q) begin
			res_st_q <= ST_OK;
			if (func_q != FN_INSERT) begin
				res_pid_q  <= bid_q;
				res_prio_q <= blevel_q;
			end
		end
		if (state_q == S_PUSH && out_free) begin
			out_st_q   <= res_st_q;
			out_pid_q  <= res_pid_q;
			out_prio_q <= res_prio_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = out_st_q;
	assign out_pid   = out_pid_q;
	assign out_prio  = out_prio_q;

`ifndef NO_ASSERTIONS
	a_cnt_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_WRITE |=> cnt_q == $past(cnt_q))
		else $error("arrival counter moved outside the write step");

	a_eval_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_s1 |-> (state_q == S_SCAN || state_q == S_DRAIN))
		else $error("slot evaluated outside the scan");

	a_no_write_while_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_DRAIN || state_q == S_IDLE) |-> !mem_we)
		else $error("pool written during a scan or while idle");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (state_q == S_IDLE && !rdv_s1))
		else $error("item taken while a scan is in flight");

	a_push_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUSH && out_free) |=> rsp_valid_q)
		else $error("result lost on the way to the output register");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for multilevel_priority_run_queue_top
// keeps its own model of the slot pool, drives directed then random items with random idling
// depends on mprq_pkg and multilevel_priority_run_queue_top
`timescale 1ns / 1ps

module testbench
	import mprq_pkg::*;
();

	localparam int NumCores   = 8;
	localparam int NumLevels  = 140;
	localparam int PoolSlots  = 64;
	localparam int RandItems  = 900;
	localparam int StallLimit = 1500;
	localparam int PlanLen    = 25;

	typedef struct {
		status_t          st;
		logic [PidW-1:0]  id;
		logic [PrioW-1:0] lvl;
	} queue_answer_t;

	typedef struct {
		func_t            op;
		logic [CoreW-1:0] core;
		logic [PrioW-1:0] prio;
		logic [PidW-1:0]  pid;
		bit               typed;
		status_t          st;
		logic [PidW-1:0]  id;
		logic [PrioW-1:0] lvl;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	logic [1:0]       func;
	logic [CoreW-1:0] core;
	logic [PrioW-1:0] prio;
	logic [PidW-1:0]  pid;
	logic             rsp_valid;
	logic             rsp_ready;
	logic [1:0]       status;
	logic [PidW-1:0]  out_pid;
	logic [PrioW-1:0] out_prio;

	multilevel_priority_run_queue_top #(
		.CORES(NumCores),
		.PRIORITIES(NumLevels),
		.SLOTS(PoolSlots)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.core(core),
		.prio(prio),
		.pid(pid),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.out_pid(out_pid),
		.out_prio(out_prio)
	);

	// model of the slot pool
	bit               pool_used  [PoolSlots];
	logic [CoreW-1:0] pool_core  [PoolSlots];
	logic [PrioW-1:0] pool_level [PoolSlots];
	logic [PidW-1:0]  pool_id    [PoolSlots];
	logic [31:0]      pool_stamp [PoolSlots];
	logic [31:0]      arrivals;

	queue_answer_t pending_answers[$];
	int            mismatch_count;
	int            idle_cycles;
	bit            steady_send;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void run_queue_step(input func_t op, input logic [CoreW-1:0] c,
			input logic [PrioW-1:0] p, input logic [PidW-1:0] id, output queue_answer_t ans);
		int best;
		logic [31:0] age_s;
		logic [31:0] age_b;
		best = -1;
		ans = '{ST_OK, '0, '0};
		case (op)
			FN_INSERT: begin
				if (int'(c) >= NumCores || int'(p) >= NumLevels) begin
					ans.st = ST_FULL;
					return;
				end
				for (int s = 0; s < PoolSlots; s++) begin
					if (!pool_used[s]) begin
						best = s;
						break;
					end
				end
				if (best < 0) begin
					ans.st = ST_FULL;
					return;
				end
				pool_used[best]  = 1'b1;
				pool_core[best]  = c;
				pool_level[best] = p;
				pool_id[best]    = id;
				pool_stamp[best] = arrivals;
				arrivals = arrivals + 32'd1;
			end
			FN_POP: begin
				if (int'(c) >= NumCores) begin
					ans.st = ST_EMPTY;
					return;
				end
				for (int s = 0; s < PoolSlots; s++) begin
					if (!pool_used[s] || pool_core[s] != c)
						continue;
					if (best < 0) begin
						best = s;
						continue;
					end
					age_s = arrivals - pool_stamp[s];
					age_b = arrivals - pool_stamp[best];
					// lowest level first, oldest within a level
					if (pool_level[s] < pool_level[best] ||
							(pool_level[s] == pool_level[best] && age_s > age_b))
						best = s;
				end
				if (best < 0) begin
					ans.st = ST_EMPTY;
					return;
				end
				pool_used[best] = 1'b0;
				ans.id  = pool_id[best];
				ans.lvl = pool_level[best];
			end
			FN_REMOVE: begin
				if (int'(c) >= NumCores || int'(p) >= NumLevels) begin
					ans.st = ST_NOTFOUND;
					return;
				end
				for (int s = 0; s < PoolSlots; s++) begin
					if (!pool_used[s] || pool_core[s] != c || pool_level[s] != p ||
							pool_id[s] != id)
						continue;
					age_s = arrivals - pool_stamp[s];
					age_b = (best < 0) ? 32'd0 : arrivals - pool_stamp[best];
					// newest matching entry goes
					if (best < 0 || age_s < age_b)
						best = s;
				end
				if (best < 0) begin
					ans.st = ST_NOTFOUND;
					return;
				end
				pool_used[best] = 1'b0;
				ans.id  = pool_id[best];
				ans.lvl = pool_level[best];
			end
			default: ;
		endcase
	endfunction

	function automatic int random_live_slot();
		int live[$];
		for (int s = 0; s < PoolSlots; s++)
			if (pool_used[s])
				live.push_back(s);
		if (live.size() == 0)
			return -1;
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady_send)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// drive one item from a falling edge and hold it until accepted
	task automatic offer_item(input func_t op, input logic [CoreW-1:0] c,
			input logic [PrioW-1:0] p, input logic [PidW-1:0] id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		func      <= op;
		core      <= c;
		prio      <= p;
		pid       <= id;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch %s: expected %0h got %0h", $realtime, what, want, got);
	endtask

	// receiver: runs of ready with stalls of random length between them
	initial begin
		int n;
		int r;
		rsp_ready = 1'b0;
		forever begin
			n = $urandom_range(1, 24);
			@(negedge clk);
			rsp_ready <= 1'b1;
			repeat (n - 1) @(negedge clk);
			r = $urandom_range(0, 99);
			n = (r < 50) ? 0 : (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
			if (n > 0) begin
				@(negedge clk);
				rsp_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		queue_answer_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_answers.size() == 0) begin
				note_mismatch("result with no item pending", 0, int'(status));
			end else begin
				want = pending_answers.pop_front();
				if (status !== want.st)
					note_mismatch("status", int'(want.st), int'(status));
				if (out_pid !== want.id)
					note_mismatch("out_pid", int'(want.id), int'(out_pid));
				if (out_prio !== want.lvl)
					note_mismatch("out_prio", int'(want.lvl), int'(out_prio));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= StallLimit) begin
			$display("** multilevel_priority_run_queue_top: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		plan_row_t        opening_plan [PlanLen];
		queue_answer_t    ans;
		func_t            op;
		logic [CoreW-1:0] c;
		logic [PrioW-1:0] p;
		logic [PidW-1:0]  id;
		int               sent;
		int               phase_len;
		int               insert_weight;
		bit               few_ids;
		int               r;
		int               s;

		opening_plan = '{
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b1, ST_EMPTY,    16'h0000, 8'd0},
			'{FN_REMOVE, 3'd0, 8'd0,   16'h0000, 1'b1, ST_NOTFOUND, 16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd0,   16'h0000, 1'b1, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd7, 8'd139, 16'hffff, 1'b1, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd0,   16'h1234, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd140, 16'hbeef, 1'b1, ST_FULL,     16'h0000, 8'd0},
			'{FN_INSERT, 3'd3, 8'd255, 16'hffff, 1'b1, ST_FULL,     16'h0000, 8'd0},
			'{FN_REMOVE, 3'd0, 8'd140, 16'h0000, 1'b1, ST_NOTFOUND, 16'h0000, 8'd0},
			'{FN_REMOVE, 3'd7, 8'd255, 16'hffff, 1'b1, ST_NOTFOUND, 16'h0000, 8'd0},
			'{FN_NOP,    3'd7, 8'd255, 16'hffff, 1'b1, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd5,   16'haaaa, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd5,   16'haaaa, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd0, 8'd5,   16'h5555, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_REMOVE, 3'd0, 8'd5,   16'haaaa, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_REMOVE, 3'd0, 8'd5,   16'h1234, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd0, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_REMOVE, 3'd7, 8'd139, 16'hffff, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd7, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd5, 8'd1,   16'h8000, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_INSERT, 3'd5, 8'd0,   16'h7fff, 1'b0, ST_OK,       16'h0000, 8'd0},
			'{FN_POP,    3'd5, 8'd0,   16'h0000, 1'b0, ST_OK,       16'h0000, 8'd0}
		};

		for (int i = 0; i < PoolSlots; i++)
			pool_used[i] = 1'b0;
		arrivals       = '0;
		mismatch_count = 0;
		idle_cycles    = 0;
		steady_send    = 1'b0;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		func      = FN_NOP;
		core      = '0;
		prio      = '0;
		pid       = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_plan[i]) begin
			offer_item(opening_plan[i].op, opening_plan[i].core, opening_plan[i].prio,
				opening_plan[i].pid);
			run_queue_step(opening_plan[i].op, opening_plan[i].core, opening_plan[i].prio,
				opening_plan[i].pid, ans);
			if (opening_plan[i].typed)
				ans = '{opening_plan[i].st, opening_plan[i].id, opening_plan[i].lvl};
			pending_answers.push_back(ans);
		end

		// phases with different insert pressure, so the pool both fills up and drains
		sent = 0;
		while (sent < RandItems) begin
			phase_len = $urandom_range(30, 90);
			case ($urandom_range(0, 3))
				0: insert_weight = 20;
				1: insert_weight = 45;
				2: insert_weight = 70;
				default: insert_weight = 92;
			endcase
			few_ids     = ($urandom_range(0, 1) != 0);
			steady_send = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < phase_len && sent < RandItems; k++) begin
				r  = $urandom_range(0, 99);
				c  = CoreW'($urandom_range(0, NumCores - 1));
				p  = ($urandom_range(0, 1) != 0) ? PrioW'($urandom_range(0, 3)) :
					PrioW'($urandom_range(0, NumLevels - 1));
				id = few_ids ? PidW'($urandom_range(0, 3)) : PidW'($urandom_range(0, 16'hffff));
				if (r < 8) begin
					// noise: unused code, level out of range, or a remove that misses
					case ($urandom_range(0, 3))
						0: op = FN_NOP;
						1: op = FN_INSERT;
						2: op = FN_REMOVE;
						default: op = FN_REMOVE;
					endcase
					if (r < 5)
						p = PrioW'($urandom_range(NumLevels, 255));
					if (op == FN_NOP)
						id = PidW'($urandom_range(0, 16'hffff));
				end else if ($urandom_range(0, 99) < insert_weight) begin
					op = FN_INSERT;
				end else begin
					s = random_live_slot();
					if ($urandom_range(0, 99) < 40) begin
						op = FN_REMOVE;
						if (s >= 0) begin
							c  = pool_core[s];
							p  = pool_level[s];
							id = pool_id[s];
						end
					end else begin
						op = FN_POP;
						if (s >= 0 && $urandom_range(0, 9) < 7)
							c = pool_core[s];
					end
				end
				offer_item(op, c, p, id);
				run_queue_step(op, c, p, id, ans);
				pending_answers.push_back(ans);
				sent++;
			end
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (PoolSlots + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** multilevel_priority_run_queue_top: PASSED **");
		else
			$display("** multilevel_priority_run_queue_top: FAILED **");
		$finish;
	end

endmodule
